// File: sv/tcw_pkg.sv
package tcw_pkg;

  // Character codes that the console interprets.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // Attribute used after reset and by the screen clear.
  localparam logic [7:0] ATTR_RESET = 8'h09;

  // Tab stops fall on multiples of this column count.
  localparam int TAB_STEP = 4;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Request operation codes.
  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Command kinds decided by the front.
  typedef enum logic [2:0] {
    CMD_READ,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_TAB,
    CMD_BACKSPACE,
    CMD_PLAIN
  } cmd_kind_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [6:0] read_col;
    logic [4:0] read_row;
    logic       read_ok;
  } cmd_t;

  // Status that the back reports to the front.
  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

// File: sv/text_console_writer.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    operation, char_code, read_col, read_row
// out       output     out_valid / out_ready  cell_char, cell_attr, cursor_col, cursor_row
// cfg       input      cfg_write              cfg_data (text attribute)
//
// After reset the screen memory is swept to blanks, one cell a cycle, and no request is taken
// until the sweep ends. The executor writes through the single memory write port; a newline
// blanks the rest of the line, and a scroll then blanks the new bottom row.
// Scrolling rotates a row base, so only the new bottom row is written.
// A two-entry queue keeps requests flowing in while the executor or the output stalls.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [0:0] operation,
  input  logic [7:0] char_code,
  input  logic [6:0] read_col,
  input  logic [4:0] read_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [7:0]        attr;
  status_t           status;
  logic              queue_full;
  logic              push;
  cmd_t              push_cmd;
  logic              head_valid;
  cmd_t              head_cmd;
  logic              cmd_pop;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [15:0]       ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [15:0]       ram_rd_data;

  // Text attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_write) begin
      attr <= cfg_data;
    end
  end

  // Request classification.
  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .char_code (char_code),
    .read_col  (read_col),
    .read_row  (read_row),
    .status    (status),
    .queue_full(queue_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Command queue between front and executor.
  tcw_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // Command executor and result register.
  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .attr       (attr),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .status     (status),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

  // Screen memory: attribute in the high byte, character in the low byte.
  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // No request is taken while the screen clear runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !in_ready)
    else $error("request accepted during screen clear");

  // Results never appear while the clear sweep is still running.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(status.clearing))
    else $error("result produced during screen clear");

  // The reported cursor row stays on the screen; the column may also sit one past the last column.
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(cursor_row) < ROWS) && (int'(cursor_col) <= COLUMNS))
    else $error("cursor out of range");

endmodule

// File: sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/tcw_front.sv
module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [0:0] operation,
  input  logic [7:0] char_code,
  input  logic [6:0] read_col,
  input  logic [4:0] read_row,
  input  status_t    status,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       cmd
);

  // Requests are refused while the screen clear runs or the queue is full.
  assign in_ready = !queue_full && !status.clearing;
  assign push     = in_valid && in_ready;

  // Classify the request and check the read position against the screen size.
  always_comb begin
    cmd.ch       = char_code;
    cmd.read_col = read_col;
    cmd.read_row = read_row;
    cmd.read_ok  = (int'(read_col) < COLUMNS) && (int'(read_row) < ROWS);
    if (operation == OP_READ) begin
      cmd.kind = CMD_READ;
    end else begin
      unique case (char_code)
        CH_NEWLINE:   cmd.kind = CMD_NEWLINE;
        CH_RETURN:    cmd.kind = CMD_RETURN;
        CH_TAB:       cmd.kind = CMD_TAB;
        CH_BACKSPACE: cmd.kind = CMD_BACKSPACE;
        default:      cmd.kind = CMD_PLAIN;
      endcase
    end
  end

endmodule

// File: sv/tcw_cmd_fifo.sv
module tcw_cmd_fifo
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;

  assign full       = (int'(count) == QUEUE_DEPTH);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: sv/tcw_back.sv
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [7:0]                            attr,
  input  logic                                  cmd_valid,
  input  cmd_t                                  cmd,
  output logic                                  cmd_pop,
  output status_t                               status,
  output logic                                  ram_wr_en,
  output logic [$clog2(ROWS*COLUMNS)-1:0]       ram_wr_addr,
  output logic [15:0]                           ram_wr_data,
  output logic [$clog2(ROWS*COLUMNS)-1:0]       ram_rd_addr,
  input  logic [15:0]                           ram_rd_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            cell_char,
  output logic [7:0]                            cell_attr,
  output logic [6:0]                            cursor_col,
  output logic [4:0]                            cursor_row
);

  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_NL,
    S_SCROLL,
    S_RD_PHYS,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ROW_W-1:0]  base, base_next;
  logic [ADDR_W-1:0] row_addr, row_addr_next;
  logic [ADDR_W-1:0] base_addr, base_addr_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [ROW_W-1:0]  rd_phys, rd_phys_next;
  logic [2:0]        cnt, cnt_next;
  cmd_t              cur_cmd, cur_cmd_next;
  logic              out_valid_next;
  logic [7:0]        cell_char_next, cell_attr_next;
  logic [6:0]        cursor_col_next;
  logic [4:0]        cursor_row_next;

  logic              finish;
  logic [7:0]        res_char, res_attr;
  logic [ADDR_W:0]   row_addr_inc, base_addr_inc;
  logic [ADDR_W-1:0] row_addr_wrap, base_addr_wrap;
  logic [ADDR_W-1:0] cur_addr;
  logic [ROW_W:0]    rd_sum;
  logic [ADDR_W-1:0] rd_addr_calc;

  assign status.clearing = (state == S_CLEAR);

  // Start addresses of the cursor row and the top row step one row at a time.
  assign row_addr_inc   = {1'b0, row_addr} + (ADDR_W+1)'(COLUMNS);
  assign base_addr_inc  = {1'b0, base_addr} + (ADDR_W+1)'(COLUMNS);
  assign row_addr_wrap  = (row_addr_inc == (ADDR_W+1)'(CELLS)) ? '0 : ADDR_W'(row_addr_inc);
  assign base_addr_wrap = (base_addr_inc == (ADDR_W+1)'(CELLS)) ? '0 : ADDR_W'(base_addr_inc);
  assign cur_addr       = row_addr + ADDR_W'(col);

  // A read row maps onto the rotated row buffer.
  assign rd_sum       = {1'b0, ROW_W'(cur_cmd.read_row)} + {1'b0, base};
  assign rd_addr_calc = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS)
                      + ADDR_W'(COL_W'(cur_cmd.read_col));
  assign ram_rd_addr  = rd_addr_calc;

  // Sequencer for the clear sweep and for each command.
  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    base_next      = base;
    row_addr_next  = row_addr;
    base_addr_next = base_addr;
    clr_addr_next  = clr_addr;
    rd_phys_next   = rd_phys;
    cnt_next       = cnt;
    cur_cmd_next   = cur_cmd;
    cmd_pop        = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = cur_addr;
    ram_wr_data    = {attr, CH_SPACE};
    finish         = 1'b0;
    res_char       = '0;
    res_attr       = '0;

    unique case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = {ATTR_RESET, CH_SPACE};
        if (int'(clr_addr) == CELLS - 1) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      S_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_pop      = 1'b1;
          cur_cmd_next = cmd;
          unique case (cmd.kind)
            CMD_READ: begin
              if (cmd.read_ok) begin
                state_next = S_RD_PHYS;
              end else begin
                finish = 1'b1;
              end
            end
            CMD_NEWLINE: begin
              state_next = S_NL;
            end
            CMD_RETURN: begin
              col_next = '0;
              finish   = 1'b1;
            end
            CMD_TAB: begin
              cur_cmd_next.ch = CH_SPACE;
              cnt_next        = 3'(TAB_STEP) - 3'(col % TAB_STEP);
              state_next      = S_PUT;
            end
            CMD_BACKSPACE: begin
              if (col != '0) begin
                col_next = col - 1'b1;
              end
              finish = 1'b1;
            end
            CMD_PLAIN: begin
              cnt_next   = 3'd1;
              state_next = S_PUT;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      // Store the character, or for a tab the spaces up to the next stop; a pending wrap first takes a line step.
      S_PUT: begin
        if (col == COL_W'(COLUMNS)) begin
          state_next = S_NL;
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_data = {attr, cur_cmd.ch};
          col_next    = col + 1'b1;
          if (cnt == 3'd1) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end

      // Blank the rest of the line, then step to the next row or scroll.
      S_NL: begin
        if (col != COL_W'(COLUMNS)) begin
          ram_wr_en = 1'b1;
          col_next  = col + 1'b1;
        end else begin
          col_next = '0;
          if (row == ROW_W'(ROWS - 1)) begin
            base_next      = (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;
            base_addr_next = base_addr_wrap;
            row_addr_next  = base_addr;
            state_next     = S_SCROLL;
          end else begin
            row_next      = row + 1'b1;
            row_addr_next = row_addr_wrap;
            if (cur_cmd.kind == CMD_NEWLINE) begin
              finish     = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_PUT;
            end
          end
        end
      end

      // The old top row becomes the new bottom row and is filled with blanks.
      S_SCROLL: begin
        ram_wr_en = 1'b1;
        if (col == COL_W'(COLUMNS - 1)) begin
          col_next = '0;
          if (cur_cmd.kind == CMD_NEWLINE) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_PUT;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end

      S_RD_PHYS: begin
        rd_phys_next = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                                    : ROW_W'(rd_sum);
        state_next   = S_RD_ADDR;
      end

      S_RD_ADDR: begin
        state_next = S_RD_DATA;
      end

      S_RD_DATA: begin
        res_char   = ram_rd_data[7:0];
        res_attr   = ram_rd_data[15:8];
        finish     = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Result register: hold until taken, load when a command completes.
    out_valid_next  = out_valid && !out_ready;
    cell_char_next  = cell_char;
    cell_attr_next  = cell_attr;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (finish) begin
      out_valid_next  = 1'b1;
      cell_char_next  = res_char;
      cell_attr_next  = res_attr;
      cursor_col_next = 7'(col_next);
      cursor_row_next = 5'(row_next);
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      col       <= '0;
      row       <= '0;
      base      <= '0;
      row_addr  <= '0;
      base_addr <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      base      <= base_next;
      row_addr  <= row_addr_next;
      base_addr <= base_addr_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
    rd_phys    <= rd_phys_next;
    cnt        <= cnt_next;
    cur_cmd    <= cur_cmd_next;
    cell_char  <= cell_char_next;
    cell_attr  <= cell_attr_next;
    cursor_col <= cursor_col_next;
    cursor_row <= cursor_row_next;
  end

endmodule

// File: test/text_console_writer_test.sv
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int SCREEN_CELLS  = SCREEN_COLS * SCREEN_ROWS;
  // The settle wait is sized for a newline with a scroll, which blanks part of one row and a whole new row.
  localparam int SETTLE_CYCLES = 2 * SCREEN_COLS + 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CHUNK_ITEMS   = 136;
  localparam int MAX_PRINTED   = 40;

  // One console request and the result that it returns.
  typedef struct {
    op_t        op;
    logic [7:0] code;
    logic [6:0] col;
    logic [4:0] row;
  } console_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } console_view_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [0:0] operation = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic [6:0] read_col = 7'd0;
  logic [4:0] read_row = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .char_code (char_code),
    .read_col  (read_col),
    .read_row  (read_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  console_req_t  pending_q[$];
  console_view_t result_q[$];
  int            items_queued = 0;
  int            mismatch_count = 0;
  logic          req_taken = 1'b0;
  logic          steady = 1'b0;
  int            hold_asks = 0;
  int            holds_served = 0;
  int            hold_left = 0;

  // Shadow copy of the screen, the cursor and the attribute register.
  logic [15:0] screen_mem [SCREEN_CELLS];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_attr;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void store_cell(int col, int row, logic [7:0] ch);
    if (col < SCREEN_COLS && row < SCREEN_ROWS) begin
      screen_mem[row * SCREEN_COLS + col] = {shadow_attr, ch};
    end
  endfunction

  // Moves every row up by one and blanks the new bottom row.
  function automatic void scroll_screen();
    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
      screen_mem[i] = screen_mem[i + SCREEN_COLS];
    end
    for (int x = 0; x < SCREEN_COLS; x++) begin
      store_cell(x, SCREEN_ROWS - 1, CH_SPACE);
    end
  endfunction

  // Blanks the rest of the line and goes to the start of the next one.
  function automatic void line_feed();
    while (shadow_col < SCREEN_COLS) begin
      store_cell(shadow_col, shadow_row, CH_SPACE);
      shadow_col++;
    end
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= SCREEN_ROWS) begin
      shadow_row = SCREEN_ROWS - 1;
      scroll_screen();
    end
  endfunction

  // A stored character wraps first when the cursor sits past the last column.
  function automatic void print_glyph(logic [7:0] ch);
    if (shadow_col >= SCREEN_COLS) begin
      line_feed();
    end
    store_cell(shadow_col, shadow_row, ch);
    shadow_col++;
  endfunction

  function automatic void interpret_char(logic [7:0] ch);
    int spaces;
    case (ch)
      CH_NEWLINE: begin
        line_feed();
      end
      CH_RETURN: begin
        shadow_col = 0;
      end
      CH_TAB: begin
        spaces = TAB_STEP - (shadow_col % TAB_STEP);
        repeat (spaces) print_glyph(CH_SPACE);
      end
      CH_BACKSPACE: begin
        if (shadow_col > 0) shadow_col--;
      end
      default: begin
        print_glyph(ch);
      end
    endcase
  endfunction

  function automatic console_view_t console_step(console_req_t r);
    console_view_t v;
    logic [15:0]   cell_word;
    v = '0;
    if (r.op == OP_PUT) begin
      interpret_char(r.code);
    end else if (r.col < SCREEN_COLS && r.row < SCREEN_ROWS) begin
      cell_word = screen_mem[r.row * SCREEN_COLS + r.col];
      v.ch      = cell_word[7:0];
      v.attr    = cell_word[15:8];
    end
    v.col = 7'(shadow_col);
    v.row = 5'(shadow_row);
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    // Keep the log short when the block is badly broken.
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // Request driver: a new request goes out only once the last one was taken.
  always @(negedge clk) begin : drive_requests
    console_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
        nxt = pending_q.pop_front();
        in_valid  <= 1'b1;
        operation <= nxt.op;
        char_code <= nxt.code;
        read_col  <= nxt.col;
        read_row  <= nxt.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready, with an occasional long hold-off.
  always @(negedge clk) begin
    if (holds_served != hold_asks) begin
      holds_served <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  // Predict each taken request and check each result against the oldest one.
  always @(posedge clk) begin : watch_console
    console_view_t want;
    console_req_t  taken;
    req_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          flag_mismatch("result with nothing expected", cell_char, 0);
        end else begin
          want = result_q.pop_front();
          if (cell_char !== want.ch) flag_mismatch("cell_char", cell_char, want.ch);
          if (cell_attr !== want.attr) flag_mismatch("cell_attr", cell_attr, want.attr);
          if (cursor_col !== want.col) flag_mismatch("cursor_col", cursor_col, want.col);
          if (cursor_row !== want.row) flag_mismatch("cursor_row", cursor_row, want.row);
        end
      end
      if (in_valid && in_ready) begin
        taken.op   = op_t'(operation);
        taken.code = char_code;
        taken.col  = read_col;
        taken.row  = read_row;
        result_q.push_back(console_step(taken));
      end
    end
  end

  task automatic queue_put(input logic [7:0] ch);
    console_req_t r;
    r.op   = OP_PUT;
    r.code = ch;
    r.col  = 7'($urandom_range(127));
    r.row  = 5'($urandom_range(31));
    pending_q.push_back(r);
    items_queued++;
  endtask

  task automatic queue_read(input int col, input int row);
    console_req_t r;
    r.op   = OP_READ;
    r.code = 8'($urandom_range(255));
    r.col  = 7'(col);
    r.row  = 5'(row);
    pending_q.push_back(r);
    items_queued++;
  endtask

  task automatic queue_cell_read();
    queue_read($urandom_range(SCREEN_COLS - 1), $urandom_range(SCREEN_ROWS - 1));
  endtask

  // Any byte that is stored as it is.
  function automatic logic [7:0] pick_glyph();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_NEWLINE || c == CH_RETURN || c == CH_TAB || c == CH_BACKSPACE);
    return c;
  endfunction

  // One random sequence; 30 percent of them fill a whole line of text.
  task automatic queue_sequence();
    int pick;
    int tabs;
    console_req_t r;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Fill a whole line so that the cursor ends on a pending wrap.
      queue_put(CH_RETURN);
      tabs = $urandom_range(20, 14);
      repeat (tabs) queue_put(CH_TAB);
      repeat (SCREEN_COLS - TAB_STEP * tabs) queue_put(pick_glyph());
      case ($urandom_range(4))
        0: queue_put(CH_NEWLINE);
        1: queue_put(CH_TAB);
        2: queue_put(CH_BACKSPACE);
        3: queue_put(pick_glyph());
        default: queue_cell_read();
      endcase
      repeat ($urandom_range(2, 1)) queue_cell_read();
    end else if (pick < 50) begin
      repeat ($urandom_range(4, 1)) queue_cell_read();
    end else if (pick < 70) begin
      repeat ($urandom_range(4, 1)) queue_put(CH_NEWLINE);
    end else if (pick < 82) begin
      repeat ($urandom_range(8, 1)) queue_put(8'($urandom_range(255)));
    end else if (pick < 92) begin
      case ($urandom_range(2))
        0: queue_put(CH_RETURN);
        1: queue_put(CH_BACKSPACE);
        default: queue_put(CH_TAB);
      endcase
    end else begin
      // Noise over the whole field ranges, reads far out of range included.
      r.op   = op_t'($urandom_range(1));
      r.code = 8'($urandom_range(255));
      r.col  = 7'($urandom_range(127));
      r.row  = 5'($urandom_range(31));
      pending_q.push_back(r);
      items_queued++;
    end
  endtask

  // Waits until every request is out and answered, then lets the block settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    shadow_attr = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_chunk(input logic [7:0] attr, input logic no_idle, input logic hold);
    int target;
    write_attribute(attr);
    steady = no_idle;
    target = items_queued + CHUNK_ITEMS;
    while (items_queued < target) queue_sequence();
    if (hold) begin
      @(posedge clk);
      hold_asks++;
    end
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SCREEN_CELLS; i++) begin
      screen_mem[i] = {ATTR_RESET, CH_SPACE};
    end
    shadow_attr = ATTR_RESET;
    shadow_col  = 0;
    shadow_row  = 0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, reads out of range, each control code.
    queue_read(0, 0);
    queue_read(SCREEN_COLS - 1, SCREEN_ROWS - 1);
    queue_read(SCREEN_COLS, 0);
    queue_read(0, SCREEN_ROWS);
    queue_read(127, 31);
    queue_put("A");
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(CH_BACKSPACE);
    queue_put(CH_RETURN);
    queue_put(CH_BACKSPACE);
    queue_put(CH_TAB);
    queue_put("x");
    queue_put(CH_TAB);
    queue_put(CH_NEWLINE);
    queue_put(8'h7F);
    queue_put(8'h80);
    queue_read(0, 0);
    queue_read(4, 0);
    queue_read(0, 1);
    queue_read(1, 1);
    wait_idle();

    // Random part over several attribute settings.
    run_chunk(8'hFF, 1'b0, 1'b0);
    run_chunk(8'h00, 1'b1, 1'b0);
    run_chunk(8'($urandom_range(255)), 1'b0, 1'b1);
    run_chunk(8'($urandom_range(255)), 1'b0, 1'b0);
    run_chunk(ATTR_RESET, 1'b0, 1'b0);

    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
